@@ hdl/hxnb_pkg.sv @@
// ----------------------------------------------------------------------------
// hxnb_pkg
// Shared types and constants for the hexahedron normals and bounds core.
// ----------------------------------------------------------------------------
package hxnb_pkg;

	typedef struct packed {
		logic [2:0]         vertex_index;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic               end_of_set;
	} hxnb_in_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic [2:0]         face_number;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic               degenerate;
		logic               last_result;
	} hxnb_out_t;

	localparam logic [1:0] KIND_NORMAL = 2'd0;
	localparam logic [1:0] KIND_MIN    = 2'd1;
	localparam logic [1:0] KIND_MAX    = 2'd2;
	localparam logic [1:0] KIND_CENTER = 2'd3;

	localparam logic [2:0] LAST_FACE = 3'd5;

	// Corners (a, b, c) of each face; the normal is (b - a) x (c - a).
	function automatic logic [2:0] face_corner(input logic [2:0] face, input logic [1:0] sel);
		logic [8:0] row;
		case (face)
			3'd0:    row = {3'd3, 3'd2, 3'd1};
			3'd1:    row = {3'd4, 3'd5, 3'd6};
			3'd2:    row = {3'd0, 3'd1, 3'd5};
			3'd3:    row = {3'd1, 3'd2, 3'd6};
			3'd4:    row = {3'd2, 3'd3, 3'd7};
			3'd5:    row = {3'd3, 3'd0, 3'd4};
			default: row = 9'd0;
		endcase
		case (sel)
			2'd0:    return row[8:6];
			2'd1:    return row[5:3];
			default: return row[2:0];
		endcase
	endfunction

endpackage

@@ hdl/hxnb_ram.sv @@
// ----------------------------------------------------------------------------
// hxnb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hxnb_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hdl/hxnb_smul.sv @@
// ----------------------------------------------------------------------------
// hxnb_smul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module hxnb_smul #(
	parameter int AW = 67
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [AW-1:0]   a,
	input  logic [AW-1:0]   b,
	output logic            done,
	output logic [2*AW-1:0] prod
);
	localparam int KW = $clog2(AW + 1);

	logic [AW-1:0] a_q, hi_q, lo_q;
	logic [KW-1:0] cnt_q;
	logic          run_q, done_q;
	logic [AW:0]   sum;

	// Partial sum of the current step; its low bit drops into the low half.
	assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : {(AW+1){1'b0}});
	assign done = done_q;
	assign prod = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == KW'(AW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (run_q) begin
			hi_q <= sum[AW:1];
			lo_q <= {sum[0], lo_q[AW-1:1]};
		end
	end
endmodule

@@ hdl/hexahedron_normals_and_bounds_core.sv @@
// ----------------------------------------------------------------------------
// hexahedron_normals_and_bounds_core
// Face unit normals and axis-aligned bounds of an eight-corner box.
// ----------------------------------------------------------------------------
// Each item transfer writes one corner (signed fixed point, FRAC_BITS fraction
// bits, wrapped to COORD_WIDTH bits) into an eight-entry corner RAM; after
// reset every corner reads as the cube at plus or minus one half until it is
// written. After a plain corner write the next item can follow at once. An
// item marked end of set starts a run that delivers nine result transfers:
// the six face unit normals, then the box minimum, maximum and center (the
// last one flagged with last_result). The run is sequenced over a single
// bit-serial multiplier of N = 2*COORD_WIDTH+3 bits, which computes the six
// cross-product terms and the three squares of each face; every squared
// component is then divided by the squared length with a restoring divider
// and square-rooted one result bit at a time. A stall on the result side
// holds the run. No new item is taken until the run has handed its last
// result to the output register.
module hexahedron_normals_and_bounds_core #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  hxnb_pkg::hxnb_in_t item,
	output logic               result_valid,
	input  logic               result_ready,
	output hxnb_pkg::hxnb_out_t result
);
	import hxnb_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int NW = 2 * W + 3;              // cross product term, signed
	localparam int LW = 2 * NW + 2;             // squared length
	localparam int DW = LW + 2 * FRAC_BITS;     // scaled dividend and divisor
	localparam int QW = 2 * FRAC_BITS + 1;      // quotient
	localparam int SW = 2 * FRAC_BITS + 2;      // square root working width
	localparam int CW = $clog2(2 * FRAC_BITS + 2);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_FETCH = 8'b0000_0010,
		ST_MUL   = 8'b0000_0100,
		ST_DIV   = 8'b0000_1000,
		ST_SQRT  = 8'b0001_0000,
		ST_EMIT  = 8'b0010_0000,
		ST_BOUND = 8'b0100_0000,
		ST_BEMIT = 8'b1000_0000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [2:0]      face_q;
	logic [3:0]      mstep_q;
	logic [1:0]      comp_q;
	logic            mul_wait_q;
	logic            deg_q;
	logic [7:0]      valid_q;
	logic            result_valid_q;
	hxnb_out_t       result_q;

	logic [2:0]      rd_idx_q;
	logic            rd_def_q;
	logic [2:0]      raddr;
	logic [3*W-1:0]  ram_rdata;
	logic [3*W-1:0]  rd_corner;
	logic signed [W-1:0] rd_v [3];

	logic signed [W-1:0] va_q [3];
	logic signed [W-1:0] vb_q [3];
	logic signed [W-1:0] vc_q [3];
	logic signed [W:0]   e1 [3];
	logic signed [W:0]   e2 [3];

	logic signed [NW-1:0] op_a, op_b;
	logic [NW-1:0]        mag_a, mag_b;
	logic                 mul_start, mul_done;
	logic [2*NW-1:0]      mul_prod;
	logic signed [NW-1:0] prod_lo, sprod;
	logic signed [NW-1:0] p_q;
	logic signed [NW-1:0] n_q [3];
	logic [2*NW-1:0]      sq_q [3];
	logic [LW-1:0]        len2_q, len2_sum;

	logic [DW-1:0]        rem_q, den_q;
	logic [QW-1:0]        quo_q;
	logic [SW-1:0]        srem_q, root_q, sbit_q, trial, root_next;
	logic signed [31:0]   root32;
	logic signed [31:0]   vec_q [3];

	logic signed [W-1:0]  mn_q [3];
	logic signed [W-1:0]  mx_q [3];
	logic signed [W:0]    csum [3];
	logic signed [W-1:0]  ctr [3];

	logic accept, load;

	// Reset value of a corner: the cube with corners at plus or minus one half.
	function automatic logic [3*W-1:0] default_corner(input logic [2:0] i);
		logic signed [W-1:0] h;
		logic xp, yp, zp;
		h  = W'(1) << (FRAC_BITS - 1);
		xp = (i == 3'd0) || (i == 3'd3) || (i == 3'd4) || (i == 3'd7);
		yp = (i == 3'd0) || (i == 3'd1) || (i == 3'd4) || (i == 3'd5);
		zp = i[2];
		return {zp ? h : -h, yp ? h : -h, xp ? h : -h};
	endfunction

	assign accept       = item_valid && item_ready;
	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign load         = ((state_q == ST_EMIT) || (state_q == ST_BEMIT)) && !result_valid_q;

	// Corner storage. Entries never written read back as the default cube.
	assign raddr = (state_q == ST_FETCH) ? face_corner(face_q, cnt_q[1:0]) : cnt_q[2:0];

	hxnb_ram #(.WIDTH(3 * W), .DEPTH(8)) u_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (item.vertex_index),
		.wdata ({W'(item.coord_z), W'(item.coord_y), W'(item.coord_x)}),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	assign rd_corner = rd_def_q ? default_corner(rd_idx_q) : ram_rdata;
	assign rd_v[0]   = rd_corner[W-1:0];
	assign rd_v[1]   = rd_corner[2*W-1:W];
	assign rd_v[2]   = rd_corner[3*W-1:2*W];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			e1[k] = (W+1)'(vb_q[k]) - (W+1)'(va_q[k]);
			e2[k] = (W+1)'(vc_q[k]) - (W+1)'(va_q[k]);
		end
	end

	// Operand schedule: six cross-product terms, then the three squares.
	always_comb begin
		case (mstep_q)
			4'd0:    begin op_a = NW'(e1[1]); op_b = NW'(e2[2]); end
			4'd1:    begin op_a = NW'(e1[2]); op_b = NW'(e2[1]); end
			4'd2:    begin op_a = NW'(e1[2]); op_b = NW'(e2[0]); end
			4'd3:    begin op_a = NW'(e1[0]); op_b = NW'(e2[2]); end
			4'd4:    begin op_a = NW'(e1[0]); op_b = NW'(e2[1]); end
			4'd5:    begin op_a = NW'(e1[1]); op_b = NW'(e2[0]); end
			4'd6:    begin op_a = n_q[0]; op_b = n_q[0]; end
			4'd7:    begin op_a = n_q[1]; op_b = n_q[1]; end
			default: begin op_a = n_q[2]; op_b = n_q[2]; end
		endcase
		mag_a = op_a[NW-1] ? NW'(-op_a) : NW'(op_a);
		mag_b = op_b[NW-1] ? NW'(-op_b) : NW'(op_b);
	end

	assign mul_start = (state_q == ST_MUL) && !mul_wait_q;

	hxnb_smul #(.AW(NW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mag_a),
		.b      (mag_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign prod_lo  = mul_prod[NW-1:0];
	assign sprod    = (op_a[NW-1] ^ op_b[NW-1]) ? -prod_lo : prod_lo;
	assign len2_sum = len2_q + LW'(mul_prod);

	// One step of the digit-by-digit square root.
	assign trial     = root_q + sbit_q;
	assign root_next = (srem_q >= trial) ? ((root_q >> 1) + sbit_q) : (root_q >> 1);
	assign root32    = 32'(root_next);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			csum[k] = (W+1)'(mn_q[k]) + (W+1)'(mx_q[k]);
			ctr[k]  = csum[k][W:1];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			face_q         <= '0;
			mstep_q        <= '0;
			comp_q         <= '0;
			mul_wait_q     <= 1'b0;
			deg_q          <= 1'b0;
			valid_q        <= '0;
			result_valid_q <= 1'b0;
			rd_def_q       <= 1'b1;
		end else begin
			rd_def_q <= !valid_q[raddr];
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						valid_q[item.vertex_index] <= 1'b1;
						if (item.end_of_set) begin
							state_q <= ST_FETCH;
							cnt_q   <= '0;
							face_q  <= '0;
						end
					end
				end
				ST_FETCH: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(3)) begin
						state_q    <= ST_MUL;
						mstep_q    <= '0;
						mul_wait_q <= 1'b0;
					end
				end
				ST_MUL: begin
					if (!mul_wait_q) begin
						mul_wait_q <= 1'b1;
					end else if (mul_done) begin
						mul_wait_q <= 1'b0;
						mstep_q    <= mstep_q + 1'b1;
						if (mstep_q == 4'd8) begin
							cnt_q  <= '0;
							comp_q <= '0;
							if (len2_sum == '0) begin
								deg_q   <= 1'b1;
								state_q <= ST_EMIT;
							end else begin
								deg_q   <= 1'b0;
								state_q <= ST_DIV;
							end
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(2 * FRAC_BITS + 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(FRAC_BITS + 1)) begin
						cnt_q  <= '0;
						comp_q <= comp_q + 1'b1;
						state_q <= (comp_q == 2'd2) ? ST_EMIT : ST_DIV;
					end
				end
				ST_EMIT: begin
					if (load) begin
						cnt_q  <= '0;
						face_q <= face_q + 1'b1;
						state_q <= (face_q == LAST_FACE) ? ST_BOUND : ST_FETCH;
					end
				end
				ST_BOUND: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(8)) begin
						state_q <= ST_BEMIT;
						mstep_q <= '0;
					end
				end
				ST_BEMIT: begin
					if (load) begin
						mstep_q <= mstep_q + 1'b1;
						if (mstep_q == 4'd2) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		rd_idx_q <= raddr;
		case (state_q)
			ST_FETCH: begin
				for (int k = 0; k < 3; k++) begin
					if (cnt_q == CW'(1)) va_q[k] <= rd_v[k];
					if (cnt_q == CW'(2)) vb_q[k] <= rd_v[k];
					if (cnt_q == CW'(3)) vc_q[k] <= rd_v[k];
				end
			end
			ST_MUL: begin
				if (mul_wait_q && mul_done) begin
					case (mstep_q)
						4'd0, 4'd2, 4'd4: p_q <= sprod;
						4'd1: n_q[0] <= p_q - sprod;
						4'd3: n_q[1] <= p_q - sprod;
						4'd5: n_q[2] <= p_q - sprod;
						4'd6: begin
							sq_q[0] <= mul_prod;
							len2_q  <= LW'(mul_prod);
						end
						4'd7: begin
							sq_q[1] <= mul_prod;
							len2_q  <= len2_sum;
						end
						default: begin
							sq_q[2] <= mul_prod;
							len2_q  <= len2_sum;
							// A face of zero area gets the unit x axis.
							vec_q[0] <= 32'sd1 <<< FRAC_BITS;
							vec_q[1] <= '0;
							vec_q[2] <= '0;
						end
					endcase
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					rem_q <= DW'(sq_q[comp_q]) << (2 * FRAC_BITS);
					den_q <= DW'(len2_q) << (2 * FRAC_BITS);
					quo_q <= '0;
				end else begin
					if (rem_q >= den_q) begin
						rem_q <= rem_q - den_q;
						quo_q <= {quo_q[QW-2:0], 1'b1};
					end else begin
						quo_q <= {quo_q[QW-2:0], 1'b0};
					end
					den_q <= den_q >> 1;
				end
			end
			ST_SQRT: begin
				if (cnt_q == '0) begin
					srem_q <= SW'(quo_q);
					root_q <= '0;
					sbit_q <= SW'(1) << (2 * FRAC_BITS);
				end else begin
					if (srem_q >= trial) begin
						srem_q <= srem_q - trial;
					end
					root_q <= root_next;
					sbit_q <= sbit_q >> 2;
					if (cnt_q == CW'(FRAC_BITS + 1)) begin
						vec_q[comp_q] <= n_q[comp_q][NW-1] ? -root32 : root32;
					end
				end
			end
			ST_BOUND: begin
				for (int k = 0; k < 3; k++) begin
					if (cnt_q == CW'(1)) begin
						mn_q[k] <= rd_v[k];
						mx_q[k] <= rd_v[k];
					end else if (cnt_q != '0) begin
						if (rd_v[k] < mn_q[k]) mn_q[k] <= rd_v[k];
						if (rd_v[k] > mx_q[k]) mx_q[k] <= rd_v[k];
					end
				end
			end
			default: ;
		endcase

		if (load) begin
			if (state_q == ST_EMIT) begin
				result_q.result_kind <= KIND_NORMAL;
				result_q.face_number <= face_q;
				result_q.vec_x       <= vec_q[0];
				result_q.vec_y       <= vec_q[1];
				result_q.vec_z       <= vec_q[2];
				result_q.degenerate  <= deg_q;
				result_q.last_result <= 1'b0;
			end else begin
				result_q.face_number <= '0;
				result_q.degenerate  <= 1'b0;
				case (mstep_q)
					4'd0: begin
						result_q.result_kind <= KIND_MIN;
						result_q.vec_x       <= 32'(mn_q[0]);
						result_q.vec_y       <= 32'(mn_q[1]);
						result_q.vec_z       <= 32'(mn_q[2]);
						result_q.last_result <= 1'b0;
					end
					4'd1: begin
						result_q.result_kind <= KIND_MAX;
						result_q.vec_x       <= 32'(mx_q[0]);
						result_q.vec_y       <= 32'(mx_q[1]);
						result_q.vec_z       <= 32'(mx_q[2]);
						result_q.last_result <= 1'b0;
					end
					default: begin
						result_q.result_kind <= KIND_CENTER;
						result_q.vec_x       <= 32'(ctr[0]);
						result_q.vec_y       <= 32'(ctr[1]);
						result_q.vec_z       <= 32'(ctr[2]);
						result_q.last_result <= 1'b1;
					end
				endcase
			end
		end
	end
endmodule
